/* hw/rtl/msd_pkg.sv */
// Package for the descending merge-sort core: sizes, the link type
// between neighboring sort cells, cell control and the controller states.
// No dependencies.
package msd_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // What one cell shows its neighbors.
  typedef struct packed {
    logic              valid;
    logic              keep;   // valid and value >= broadcast value
    logic [DATA_W-1:0] value;
  } link_t;

  // Common control broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

/* hw/rtl/msd_cell.sv */
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on msd_pkg.
module msd_cell
  import msd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] din_i,
  input  link_t             prev_i,
  input  link_t             next_i,
  output link_t             link_o
);

  logic              valid_r;
  logic              valid_nxt;
  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;
  logic              keep;

  assign keep = valid_r && ($signed(value_r) >= $signed(din_i));

  assign link_o = '{valid: valid_r, keep: keep, value: value_r};

  // On a shift each cell takes the next cell's value. On an insert a cell keeps
  // its value when it holds one not smaller than the new one; the first cell
  // that does not keep takes the new value, and the rest move one place down.
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl_i.shift) begin
      valid_nxt = next_i.valid;
      value_nxt = next_i.value;
    end else if (ctrl_i.insert && !keep) begin
      if (prev_i.keep) begin
        valid_nxt = 1'b1;
        value_nxt = din_i;
      end else begin
        valid_nxt = prev_i.valid;
        value_nxt = prev_i.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

/* hw/rtl/merge_sort_descending_core.sv */
// Top level of the descending sort core: controller and a chain of sort cells.
// Depends on msd_pkg and msd_cell.
//
// Usage: values arrive on the in_ channel, one per transfer, with in_last_in
// high on the final value of a set. The core holds up to CAPACITY values in
// a chain of cells kept in descending order at all times: each accepted
// value is placed in its slot in the same cycle, so the chain can take a
// new value every cycle. Values that arrive once the chain is full are
// dropped, and out_overflow is then high on every result of that set (the
// closing value counts too).
// After the closing transfer in_ready goes low and the results come out on
// the out_ channel the next cycle, largest first, one per cycle while
// out_ready is high; out_last_out marks the smallest. Each output transfer
// shifts the whole chain one cell toward the head, so the head cell register
// drives the result ports directly. A stalled receiver simply holds the
// chain and the result steady. After the final transfer in_ready rises
// again in the next cycle. Reset empties the chain and returns the core to
// loading; no clearing pass is needed.
module merge_sort_descending_core
  import msd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_last_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_sorted_value,
  output logic              out_last_out,
  output logic              out_overflow
);

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             dropped_r;
  logic             dropped_nxt;

  logic       in_xfer;
  logic       out_xfer;
  logic       full;
  cell_ctrl_t ctrl;

  link_t links [CAPACITY];
  link_t head_prev;
  link_t tail_next;

  assign in_ready = (state_r == ST_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign full     = (count_r == CNT_CAP);

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = out_xfer;

  // The head cell always sees a neighbor that "keeps", so it takes the new value
  // when empty or its own is smaller; the tail sees an empty cell behind it.
  assign head_prev = '{valid: 1'b0, keep: 1'b1, value: '0};
  assign tail_next = '{valid: 1'b0, keep: 1'b0, value: '0};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      msd_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl_i (ctrl),
        .din_i  (in_value),
        .prev_i ((gi == 0) ? head_prev : links[(gi == 0) ? 0 : gi - 1]),
        .next_i ((gi == CAPACITY - 1) ? tail_next
                                      : links[(gi == CAPACITY - 1) ? gi : gi + 1]),
        .link_o (links[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_ONE;
          end
          if (in_last_in) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_xfer) begin
          count_nxt = count_r - CNT_ONE;
          if (count_r == CNT_ONE) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign out_valid        = (state_r == ST_DRAIN);
  assign out_sorted_value = links[0].value;
  assign out_last_out     = (count_r == CNT_ONE);
  assign out_overflow     = dropped_r;

`ifndef NO_ASSERTIONS
  // While results are offered the head cell holds a stored value.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> links[0].valid)
    else $error("result offered from an empty head cell");

  // The head cell and the one behind it stay in descending order.
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (links[0].valid && links[1].valid) |->
      ($signed(links[0].value) >= $signed(links[1].value)))
    else $error("sort chain out of order at the head");

  // When the last result of a set is offered, the cell behind the head is empty.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |-> !links[1].valid)
    else $error("element count disagrees with chain occupancy");

  // After the final result the core is ready to load again.
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_out) |=> (in_ready && !links[0].valid))
    else $error("core not empty and ready after the last result");
`endif

endmodule

/* sim/merge_sort_descending_checker.sv */
`timescale 1ns / 1ps
// Checker for the descending sort core: watches both channels, predicts the
// sorted output of every set and compares it field by field. Depends on msd_pkg.
module merge_sort_descending_checker
  import msd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_last_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] out_sorted_value,
  input  logic              out_last_out,
  input  logic              out_overflow,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last_out;
    logic              overflow;
  } sorted_result_t;

  logic signed [DATA_W-1:0] set_values [CAPACITY];
  int                       set_size;
  logic                     set_dropped;
  sorted_result_t           sorted_q [$];
  int                       errors;

  // Sorts the collected set largest first and queues one result per value.
  function automatic void queue_sorted_set();
    logic signed [DATA_W-1:0] ordered [CAPACITY];
    logic signed [DATA_W-1:0] moving;
    sorted_result_t           entry;
    int                       j;
    for (int i = 0; i < set_size; i++) ordered[i] = set_values[i];
    for (int i = 1; i < set_size; i++) begin
      moving = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1] < moving) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = moving;
    end
    for (int i = 0; i < set_size; i++) begin
      entry.value    = ordered[i];
      entry.last_out = (i == set_size - 1);
      entry.overflow = set_dropped;
      sorted_q.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin : monitor
    sorted_result_t seen;
    sorted_result_t want;
    if (!rst_n) begin
      set_size    = 0;
      set_dropped = 1'b0;
      errors      = 0;
      sorted_q.delete();
    end else begin
      // Results are checked before the input, since a closing transfer
      // cannot produce a result at the same edge.
      if (out_valid && out_ready) begin
        seen = '{out_sorted_value, out_last_out, out_overflow};
        if (sorted_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with none pending: value %0d last_out %b overflow %b",
                     $time, $signed(seen.value), seen.last_out, seen.overflow);
        end else begin
          want = sorted_q.pop_front();
          if (seen.value !== want.value || seen.last_out !== want.last_out ||
              seen.overflow !== want.overflow) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch: expected %0d/%b/%b, got %0d/%b/%b", $time,
                       $signed(want.value), want.last_out, want.overflow,
                       $signed(seen.value), seen.last_out, seen.overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (set_size < CAPACITY) begin
          set_values[set_size] = in_value;
          set_size++;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_last_in) begin
          queue_sorted_set();
          set_size    = 0;
          set_dropped = 1'b0;
        end
      end
    end
    fail_count    <= errors;
    pending_count <= sorted_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the descending sort core: clock, reset, stimulus and the
// verdict. Depends on msd_pkg, merge_sort_descending_core and the checker.
module tb
  import msd_pkg::*;
();

  localparam int ITEM_TARGET  = 260;
  localparam int LONG_HOLD    = 300;   // cycles the receiver refuses results once
  localparam int HOLD_AFTER   = 30;    // output transfers before that hold starts
  localparam int PAUSE_AFTER  = 200;   // input transfers before the sender drains the core
  localparam int STALL_LIMIT  = 1000;  // cycles without any transfer before giving up
  localparam int SETTLE_WAIT  = 20;    // extra cycles after the last expected result

  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic [DATA_W-1:0] in_value   = '0;
  logic              in_last_in = 1'b0;
  logic              out_ready  = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [DATA_W-1:0] out_sorted_value;
  logic              out_last_out;
  logic              out_overflow;

  int fail_count;
  int pending_count;
  int items_sent    = 0;
  int burst_left    = 0;
  int out_transfers = 0;
  int idle_cycles   = 0;

  merge_sort_descending_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

  merge_sort_descending_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offers one value and returns once its transfer has happened.
  // The sender works in bursts: while a burst lasts, in_valid stays high and
  // the next call simply puts a new payload on the ports in the same step.
  // When the burst runs out, in_valid drops for a random gap before the next
  // burst, so gaps land in the middle of sets as well as between them.
  task automatic send_item(input logic [DATA_W-1:0] value, input logic closing);
    in_valid   <= 1'b1;
    in_value   <= value;
    in_last_in <= closing;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // A mix of the extremes, a narrow band around zero that yields many equal
  // values, and full-width random values that toggle every bit.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
      default: return DATA_W'($urandom());
    endcase
  endfunction

  task automatic send_set(input int count);
    for (int i = 0; i < count; i++) send_item(pick_value(), i == count - 1);
  endtask

  // Stops offering and waits until the checker has seen every result it
  // expects. It must be called in the step of the last transfer, so that the
  // accepted payload is not offered a second time.
  task automatic drain_core();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // The receiver switches between being always ready, stalling at random and
  // stalling most of the time, each for a random stretch. Once, after a few
  // dozen results, it refuses results for a long stretch; the core then holds
  // its result and keeps in_ready low while the sender keeps offering.
  initial begin : receiver
    int  mode;
    int  stretch;
    bit  held_once;
    held_once = 1'b0;
    forever begin
      if (!held_once && out_transfers >= HOLD_AFTER) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(1, 40);
      repeat (stretch) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // The watchdog ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (out_valid && out_ready) out_transfers <= out_transfers + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int  set_len;
    bit  paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets. A single value at each extreme gives a one-result set
    // whose only result carries last_out.
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b1);
    // Extremes and the values around zero, in scrambled order, so the sign
    // handling of the ordering is exercised.
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(DATA_W'(1), 1'b1);
    // Repeated values, which may come out in any order among themselves.
    send_item(DATA_W'(7), 1'b0);
    send_item(DATA_W'(7), 1'b0);
    send_item(DATA_W'(-7), 1'b0);
    send_item(DATA_W'(7), 1'b1);
    // Two values already in descending order, then an ascending run that the
    // core must fully reverse.
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);
    for (int i = 1; i <= 6; i++) send_item(DATA_W'(i), i == 6);

    // Let the core empty completely before the random part starts.
    drain_core();

    // A set that fills the store exactly, with no overflow, and one that is a
    // value longer, so the closing value itself is dropped and flags overflow.
    send_set(CAPACITY);
    send_set(CAPACITY + 1);

    // Random sets: mostly short, now and then around the capacity so that
    // overflow comes up with several dropped values too.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) set_len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
      else set_len = $urandom_range(1, 12);
      send_set(set_len);
      if (!paused && items_sent >= PAUSE_AFTER) begin
        paused = 1'b1;
        drain_core();
      end
    end

    drain_core();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
